// ===== rtl/core/mvsm_pkg.sv =====
// shared types, constants and codes for the multi-voice sample mixer
`default_nettype none
package mvsm_pkg;

    // sizing of the mixer
    localparam int VOICE_COUNT      = 8;
    localparam int SAMPLE_ADDR_BITS = 16;
    localparam int OUTPUT_RATE      = 44100;

    localparam int VOICE_IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int MASK_N      = (VOICE_COUNT < 8) ? VOICE_COUNT : 8;

    // cursor is 18.16 with headroom past the longest effect
    localparam int FRAC_W    = 16;
    localparam int CURSOR_W  = 34;
    localparam int FRAME_W   = CURSOR_W - FRAC_W;
    localparam int FRAMES_W  = 17;

    // step = (rate << 16) / OUTPUT_RATE, rate of zero stands for OUTPUT_RATE
    localparam longint MAX_STEP_RAW = (64'd65535 << 16) / OUTPUT_RATE;
    localparam longint MAX_STEP     = (MAX_STEP_RAW > 65536) ? MAX_STEP_RAW : 65536;
    localparam int STEP_W           = $clog2(MAX_STEP + 1);
    localparam int RATE_W           = ($clog2(OUTPUT_RATE + 1) > 16) ?
                                      $clog2(OUTPUT_RATE + 1) : 16;

    // step by reciprocal multiply: (rate * RECIP) >> RECIP_SHIFT, exact for
    // every rate below 2^RATE_W since the rounding error stays under 1/OUTPUT_RATE
    localparam int     RECIP_SHIFT = RATE_W + $clog2(OUTPUT_RATE);
    localparam longint RECIP       = ((longint'(1) << (FRAC_W + RECIP_SHIFT))
                                      + OUTPUT_RATE - 1) / OUTPUT_RATE;
    localparam int     RECIP_W     = $clog2(RECIP + 1);

    // address arithmetic width before wrapping to the memory size
    localparam int ADDR_FULL_W = (SAMPLE_ADDR_BITS > 20) ? SAMPLE_ADDR_BITS : 20;

    // mix accumulator holds music plus every voice
    localparam int SUM_W = 16 + $clog2(VOICE_COUNT + 1);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_CLAIM,
        S_TCHECK,
        S_TLEFT,
        S_TRIGHT,
        S_TDONE
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [15:0]        address;
        logic signed [15:0] sample_word;
        logic [16:0]        sample_count;
        logic               stereo;
        logic [15:0]        play_rate;
        logic signed [15:0] music_left;
        logic signed [15:0] music_right;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [7:0]         active_mask;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/mvsm_sample_ram.sv =====
// single-port sample memory with registered read data
`default_nettype none
module mvsm_sample_ram
(
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic                                  we,
    input  wire logic [mvsm_pkg::SAMPLE_ADDR_BITS-1:0] addr,
    input  wire logic signed [15:0]                    wdata,
    output      logic signed [15:0]                    rdata
);
    import mvsm_pkg::*;

    logic signed [15:0] mem [2**SAMPLE_ADDR_BITS];
    logic signed [15:0] rdata_reg;

    // write or read one word per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mvsm_rate_div.sv =====
// reciprocal multiplier for the cursor step (rate << 16) / OUTPUT_RATE
`default_nettype none
module mvsm_rate_div
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic [15:0]                 rate,
    output      logic                        done,
    output      logic [mvsm_pkg::STEP_W-1:0] step
);
    import mvsm_pkg::*;

    localparam int PROD_W = RATE_W + RECIP_W;

    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RATE_W-1:0] rate_eff;
    logic [PROD_W-1:0] prod;

    // zero rate means play at the output rate
    assign rate_eff = (rate == 16'd0) ? RATE_W'(OUTPUT_RATE) : RATE_W'(rate);

    // constant multiply, the quotient sits above the reciprocal's fraction bits
    assign prod = PROD_W'(rate_eff) * PROD_W'(RECIP);

    // capture the step in the go cycle, done follows in the next cycle
    always_comb
    begin
        done_next = go;
        step_next = step_reg;
        if (go)
        begin
            step_next = prod[RECIP_SHIFT +: STEP_W];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign step = step_reg;

endmodule
`default_nettype wire

// ===== rtl/core/multi_voice_sample_mixer.sv =====
// multi-voice sample playback mixer: sequencer, voice state and mix accumulators
//
// Usage: an item is presented on cmd and taken at a clock edge where start is
// high and busy is low. op selects tick, start voice, stop all, or write word.
// Write, stop and a start with zero count finish in the accept cycle and never
// raise busy. A start forms the cursor step with a reciprocal multiply (S_DIV),
// then claims the first idle voice (S_CLAIM); when all voices are busy, a scan
// of one voice per cycle (S_SCAN) picks the one to steal before the claim.
// A tick loads the music into the sums and walks the voices through one shared
// memory port: a check for an idle or ending voice, a check and a left read for
// a mono voice, and a check, a left and a right read for a stereo voice; S_TDONE
// then saturates the sums and registers the output. The result shows on
// result for exactly one cycle with result_valid high, the same cycle busy
// falls; it cannot be held off. Reset clears all voices and the sequencer;
// sample memory is not cleared and must be written before it is played.
`default_nettype none
module multi_voice_sample_mixer
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output      logic           busy,
    input  wire mvsm_pkg::cmd_t cmd,
    output      logic           result_valid,
    output      mvsm_pkg::res_t result
);
    import mvsm_pkg::*;

    // sequencer and control
    state_t                   state_reg, state_next;
    logic [VOICE_IDX_W-1:0]   idx_reg, idx_next;
    logic                     valid_reg, valid_next;
    logic [VOICE_COUNT-1:0]   active_reg, active_next;

    // working registers
    logic [VOICE_IDX_W-1:0]      pick_reg, pick_next;
    logic [CURSOR_W-1:0]         best_reg, best_next;
    logic [SAMPLE_ADDR_BITS-1:0] addr_reg, addr_next;
    logic signed [SUM_W-1:0]     lsum_reg, lsum_next;
    logic signed [SUM_W-1:0]     rsum_reg, rsum_next;
    res_t                        res_reg, res_next;
    logic [15:0]                 st_addr_reg, st_addr_next;
    logic [16:0]                 st_count_reg, st_count_next;
    logic                        st_stereo_reg, st_stereo_next;

    // voice state
    logic [15:0]          base_reg   [VOICE_COUNT];
    logic [FRAMES_W-1:0]  frames_reg [VOICE_COUNT];
    logic                 stereo_reg [VOICE_COUNT];
    logic [CURSOR_W-1:0]  cursor_reg [VOICE_COUNT];
    logic [STEP_W-1:0]    step_reg   [VOICE_COUNT];

    logic                        accept;
    logic                        claim, advance, deactivate, stop_all, div_go;
    logic                        div_done;
    logic [STEP_W-1:0]           div_step;
    logic                        mem_en, mem_we;
    logic [SAMPLE_ADDR_BITS-1:0] mem_addr;
    logic signed [15:0]          mem_rdata;
    logic [ADDR_FULL_W-1:0]      wr_addr_full;
    logic [ADDR_FULL_W-1:0]      voice_addr_full;
    logic [ADDR_FULL_W-1:0]      voice_offset;
    logic [FRAME_W-1:0]          frame;
    logic [VOICE_IDX_W-1:0]      first_idle;
    logic                        last_voice;
    state_t                      after_voice_state;
    logic [VOICE_IDX_W-1:0]      after_voice_idx;
    logic [7:0]                  mask;

    function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [15:0] r;
        if (v > SUM_W'(32767))
        begin
            r = 16'sd32767;
        end
        else if (v < -SUM_W'(32768))
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // step divider
    mvsm_rate_div u_rate_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .rate  (cmd.play_rate),
        .done  (div_done),
        .step  (div_step)
    );

    // sample memory
    mvsm_sample_ram u_sample_ram
    (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (cmd.sample_word),
        .rdata (mem_rdata)
    );

    // address of the current voice frame, wrapped to the memory size
    assign wr_addr_full    = ADDR_FULL_W'(cmd.address);
    assign frame           = cursor_reg[idx_reg][CURSOR_W-1:FRAC_W];
    assign voice_offset    = stereo_reg[idx_reg] ? ADDR_FULL_W'({frame, 1'b0})
                                                 : ADDR_FULL_W'(frame);
    assign voice_addr_full = ADDR_FULL_W'(base_reg[idx_reg]) + voice_offset;

    // lowest idle voice
    always_comb
    begin
        first_idle = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                first_idle = VOICE_IDX_W'(i);
            end
        end
    end

    // active mask shows the first eight voices
    always_comb
    begin
        mask = '0;
        for (int i = 0; i < MASK_N; i++)
        begin
            mask[i] = active_reg[i];
        end
    end

    // where the walk goes after the current voice
    assign last_voice        = (idx_reg == VOICE_IDX_W'(VOICE_COUNT - 1));
    assign after_voice_state = last_voice ? S_TDONE : S_TCHECK;
    assign after_voice_idx   = last_voice ? idx_reg : idx_reg + 1'b1;

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        valid_next     = 1'b0;
        pick_next      = pick_reg;
        best_next      = best_reg;
        addr_next      = addr_reg;
        lsum_next      = lsum_reg;
        rsum_next      = rsum_reg;
        res_next       = res_reg;
        st_addr_next   = st_addr_reg;
        st_count_next  = st_count_reg;
        st_stereo_next = st_stereo_reg;
        claim          = 1'b0;
        advance        = 1'b0;
        deactivate     = 1'b0;
        stop_all       = 1'b0;
        div_go         = 1'b0;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = wr_addr_full[SAMPLE_ADDR_BITS-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.op)
                        OP_WRITE:
                        begin
                            mem_en = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_STOP:
                        begin
                            stop_all = 1'b1;
                        end
                        OP_START:
                        begin
                            if (cmd.sample_count != 17'd0)
                            begin
                                div_go         = 1'b1;
                                st_addr_next   = cmd.address;
                                st_count_next  = cmd.sample_count;
                                st_stereo_next = cmd.stereo;
                                state_next     = S_DIV;
                            end
                        end
                        OP_TICK:
                        begin
                            lsum_next  = SUM_W'(cmd.music_left);
                            rsum_next  = SUM_W'(cmd.music_right);
                            idx_next   = '0;
                            state_next = S_TCHECK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (&active_reg)
                    begin
                        idx_next   = '0;
                        best_next  = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        pick_next  = first_idle;
                        state_next = S_CLAIM;
                    end
                end
            end
            S_SCAN:
            begin
                // greatest cursor wins, later voice on a tie
                if (cursor_reg[idx_reg] >= best_reg)
                begin
                    best_next = cursor_reg[idx_reg];
                    pick_next = idx_reg;
                end
                if (last_voice)
                begin
                    state_next = S_CLAIM;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CLAIM:
            begin
                claim      = 1'b1;
                state_next = S_IDLE;
            end
            S_TCHECK:
            begin
                if (!active_reg[idx_reg])
                begin
                    idx_next   = after_voice_idx;
                    state_next = after_voice_state;
                end
                else if (frame >= FRAME_W'(frames_reg[idx_reg]))
                begin
                    deactivate = 1'b1;
                    idx_next   = after_voice_idx;
                    state_next = after_voice_state;
                end
                else
                begin
                    mem_en     = 1'b1;
                    mem_addr   = voice_addr_full[SAMPLE_ADDR_BITS-1:0];
                    addr_next  = voice_addr_full[SAMPLE_ADDR_BITS-1:0];
                    state_next = S_TLEFT;
                end
            end
            S_TLEFT:
            begin
                lsum_next = lsum_reg + SUM_W'(mem_rdata);
                if (stereo_reg[idx_reg])
                begin
                    mem_en     = 1'b1;
                    mem_addr   = addr_reg + 1'b1;
                    state_next = S_TRIGHT;
                end
                else
                begin
                    rsum_next  = rsum_reg + SUM_W'(mem_rdata);
                    advance    = 1'b1;
                    idx_next   = after_voice_idx;
                    state_next = after_voice_state;
                end
            end
            S_TRIGHT:
            begin
                rsum_next  = rsum_reg + SUM_W'(mem_rdata);
                advance    = 1'b1;
                idx_next   = after_voice_idx;
                state_next = after_voice_state;
            end
            S_TDONE:
            begin
                res_next.left        = sat16(lsum_reg);
                res_next.right       = sat16(rsum_reg);
                res_next.active_mask = mask;
                valid_next           = 1'b1;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // active bits
    always_comb
    begin
        active_next = active_reg;
        if (stop_all)
        begin
            active_next = '0;
        end
        if (claim)
        begin
            active_next[pick_reg] = 1'b1;
        end
        if (deactivate)
        begin
            active_next[idx_reg] = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            valid_reg  <= 1'b0;
            active_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            valid_reg  <= valid_next;
            active_reg <= active_next;
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        pick_reg      <= pick_next;
        best_reg      <= best_next;
        addr_reg      <= addr_next;
        lsum_reg      <= lsum_next;
        rsum_reg      <= rsum_next;
        res_reg       <= res_next;
        st_addr_reg   <= st_addr_next;
        st_count_reg  <= st_count_next;
        st_stereo_reg <= st_stereo_next;
    end

    // voice payload: claim loads a voice, advance moves its cursor
    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            base_reg[pick_reg]   <= st_addr_reg;
            stereo_reg[pick_reg] <= st_stereo_reg;
            frames_reg[pick_reg] <= st_stereo_reg ? {1'b0, st_count_reg[16:1]}
                                                  : st_count_reg;
            cursor_reg[pick_reg] <= '0;
            step_reg[pick_reg]   <= div_step;
        end
        if (advance)
        begin
            cursor_reg[idx_reg] <= cursor_reg[idx_reg] + CURSOR_W'(step_reg[idx_reg]);
        end
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

`ifndef NO_ASSERTIONS
    // writes and stops finish in the accept cycle
    a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == OP_WRITE || cmd.op == OP_STOP)) |=> !busy)
        else $error("single-cycle item raised busy");

    // a tick always enters the voice walk
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == OP_TICK) |=> (busy && state_reg == S_TCHECK))
        else $error("tick item did not start the voice walk");

    // a result strobe lasts one cycle and the sequencer is back at rest
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!busy && $past(state_reg) == S_TDONE))
        else $error("result strobe outside the end of a tick");

    // the right-channel read belongs to a stereo voice
    a_right_stereo: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRIGHT) |-> (stereo_reg[idx_reg] && active_reg[idx_reg]))
        else $error("right-channel read on a mono or idle voice");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the multi-voice sample mixer
`default_nettype none
module testbench;
    import mvsm_pkg::*;

    localparam int MEM_WORDS   = 1 << SAMPLE_ADDR_BITS;
    localparam longint ADDR_MASK = (longint'(1) << SAMPLE_ADDR_BITS) - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 64;
    // playback region, contiguous across the address wrap
    localparam int LOAD_BASE   = 16'hFFC0;
    localparam int LOAD_WORDS  = 256;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic result_valid;
    res_t result;

    // mirror of the mixer state
    logic [15:0] sample_mem [0:MEM_WORDS-1];
    bit          voice_on [VOICE_COUNT];
    logic [15:0] voice_addr [VOICE_COUNT];
    logic [16:0] voice_len [VOICE_COUNT];
    bit          voice_is_stereo [VOICE_COUNT];
    logic [33:0] voice_pos [VOICE_COUNT];
    logic [16:0] voice_inc [VOICE_COUNT];

    res_t expected_frames [$];
    int   error_count;
    int   cycle_count;
    int   gap_pct;

    multi_voice_sample_mixer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // compare each output frame with the oldest expected one
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_valid)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("output frame with none expected: left %0d right %0d mask %h",
                       result.left, result.right, result.active_mask);
                error_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                if (result.left !== want.left)
                begin
                    $error("left mismatch: expected %0d, got %0d", want.left, result.left);
                    error_count++;
                end
                if (result.right !== want.right)
                begin
                    $error("right mismatch: expected %0d, got %0d", want.right, result.right);
                    error_count++;
                end
                if (result.active_mask !== want.active_mask)
                begin
                    $error("active_mask mismatch: expected %h, got %h",
                           want.active_mask, result.active_mask);
                    error_count++;
                end
            end
        end
    end

    // apply one accepted item to the mirror, queue the frame a tick produces
    task automatic update_mixer_state(input cmd_t c);
        longint frame_idx;
        longint rd_addr;
        longint top_pos;
        int     pick;
        int     src_rate;
        int     lsum;
        int     rsum;
        int     lval;
        int     rval;
        res_t   frame;
        case (c.op)
            OP_WRITE:
            begin
                sample_mem[longint'(c.address) & ADDR_MASK] = c.sample_word;
            end
            OP_STOP:
            begin
                for (int i = 0; i < VOICE_COUNT; i++)
                    voice_on[i] = 1'b0;
            end
            OP_START:
            begin
                if (c.sample_count != 0)
                begin
                    src_rate = (c.play_rate == 0) ? OUTPUT_RATE : int'(c.play_rate);
                    pick = -1;
                    for (int i = 0; i < VOICE_COUNT; i++)
                        if (!voice_on[i] && pick < 0)
                            pick = i;
                    // every voice busy: take the furthest along, last one on a tie
                    if (pick < 0)
                    begin
                        top_pos = 0;
                        for (int i = 0; i < VOICE_COUNT; i++)
                        begin
                            if (longint'(voice_pos[i]) >= top_pos)
                            begin
                                top_pos = longint'(voice_pos[i]);
                                pick = i;
                            end
                        end
                    end
                    voice_addr[pick]      = c.address;
                    voice_is_stereo[pick] = c.stereo;
                    voice_len[pick]       = c.stereo ? (c.sample_count >> 1) : c.sample_count;
                    voice_pos[pick]       = '0;
                    voice_inc[pick]       = 17'((longint'(src_rate) << 16) / OUTPUT_RATE);
                    voice_on[pick]        = 1'b1;
                end
            end
            default:
            begin
                lsum = $signed(c.music_left);
                rsum = $signed(c.music_right);
                for (int i = 0; i < VOICE_COUNT; i++)
                begin
                    if (voice_on[i])
                    begin
                        frame_idx = longint'(voice_pos[i] >> 16);
                        if (frame_idx >= longint'(voice_len[i]))
                            voice_on[i] = 1'b0;
                        else
                        begin
                            rd_addr = longint'(voice_addr[i])
                                      + (voice_is_stereo[i] ? frame_idx * 2 : frame_idx);
                            lval = $signed(sample_mem[rd_addr & ADDR_MASK]);
                            rval = voice_is_stereo[i] ?
                                   $signed(sample_mem[(rd_addr + 1) & ADDR_MASK]) : lval;
                            lsum += lval;
                            rsum += rval;
                            voice_pos[i] = voice_pos[i] + voice_inc[i];
                        end
                    end
                end
                if (lsum > 32767) lsum = 32767;
                else if (lsum < -32768) lsum = -32768;
                if (rsum > 32767) rsum = 32767;
                else if (rsum < -32768) rsum = -32768;
                frame.left  = lsum[15:0];
                frame.right = rsum[15:0];
                frame.active_mask = '0;
                for (int i = 0; i < VOICE_COUNT && i < 8; i++)
                    frame.active_mask[i] = voice_on[i];
                expected_frames.push_back(frame);
            end
        endcase
    endtask

    // present one item and hold it until the mixer takes it
    task automatic send_item(input cmd_t c);
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        update_mixer_state(c);
    endtask

    // random pause on the sending side
    task automatic pace;
        if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // hold off until every expected frame has come back
    task automatic wait_drained;
        start <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
    endtask

    // item with every field random and the given operation
    function automatic cmd_t random_item(input op_t kind);
        cmd_t c;
        c.op           = kind;
        c.address      = 16'($urandom_range(0, 65535));
        c.sample_word  = 16'($urandom_range(0, 65535));
        c.sample_count = 17'($urandom_range(0, 65536));
        c.stereo       = 1'($urandom_range(0, 1));
        c.play_rate    = 16'($urandom_range(0, 65535));
        c.music_left   = 16'($urandom_range(0, 65535));
        c.music_right  = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    function automatic cmd_t tick_item(input int ml, input int mr);
        cmd_t c;
        c = random_item(OP_TICK);
        c.music_left  = ml[15:0];
        c.music_right = mr[15:0];
        return c;
    endfunction

    function automatic cmd_t start_item(input int base, input int count,
                                        input bit st, input int rate);
        cmd_t c;
        c = random_item(OP_START);
        c.address      = base[15:0];
        c.sample_count = count[16:0];
        c.stereo       = st;
        c.play_rate    = rate[15:0];
        return c;
    endfunction

    // ticks with no voice playing, music at its extremes, then a stop
    task automatic test_idle_ticks;
        send_item(tick_item(32767, -32768));
        pace();
        send_item(tick_item(-32768, 32767));
        pace();
        send_item(random_item(OP_STOP));
        pace();
    endtask

    // write the playback region once so no voice reads unwritten memory
    task automatic load_sample_memory;
        cmd_t c;
        for (int k = 0; k < LOAD_WORDS; k++)
        begin
            c = random_item(OP_WRITE);
            c.address = 16'(LOAD_BASE + k);
            // full-scale regions for saturation
            if (c.address >= 16'h0040 && c.address < 16'h0060)
                c.sample_word = 16'sh7FFF;
            else if (c.address >= 16'h0060 && c.address < 16'h0080)
                c.sample_word = 16'sh8000;
            send_item(c);
        end
    endtask

    // zero-length start, address wrap, short stereo, voice end
    task automatic test_voice_lifecycle;
        send_item(start_item(16'h1234, 0, 1'b0, 44100));
        pace();
        send_item(start_item(16'hFFFE, 3, 1'b0, 0));
        pace();
        send_item(start_item(16'hFFFF, 3, 1'b1, 44100));
        pace();
        send_item(start_item(16'h0300, 1, 1'b1, 8000));
        pace();
        send_item(start_item(16'h0080, 2, 1'b0, 22050));
        pace();
        for (int n = 0; n < 5; n++)
        begin
            send_item(tick_item(0, 0));
            pace();
        end
    endtask

    // fill every voice, steal on a tie and after a tick, saturate the mix
    task automatic test_voice_steal;
        send_item(random_item(OP_STOP));
        pace();
        for (int v = 0; v < 8; v++)
        begin
            if (v == 3)
                send_item(start_item(16'h0040, 65536, 1'b1, 65535));
            else
                send_item(start_item(16'h0040 + v, 24, 1'b0, (v % 2) ? 0 : 65535));
            pace();
        end
        send_item(start_item(16'h0060, 32, 1'b0, 30000));
        pace();
        send_item(tick_item(32767, 32767));
        pace();
        send_item(start_item(16'h0061, 16, 1'b1, 0));
        pace();
        send_item(random_item(OP_STOP));
        pace();
        send_item(tick_item(0, -1));
        pace();
    endtask

    // random mix of writes, starts, stops and ticks
    task automatic test_random_traffic;
        cmd_t c;
        int   pick;
        for (int n = 0; n < 520; n++)
        begin
            // change the idling pattern every stretch, none near the end
            if (n % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 40;
                endcase
            end
            if (n >= 440)
                gap_pct = 0;
            if (n == 260)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 45)
                c = random_item(OP_TICK);
            else if (pick < 70)
            begin
                c = random_item(OP_START);
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    c.sample_count = 0;
                else if (pick < 85)
                    c.sample_count = 17'($urandom_range(1, 64));
                else
                    c.sample_count = 17'($urandom_range(1, LOAD_WORDS));
                // effect lies wholly inside the playback region
                c.address = 16'(LOAD_BASE
                                + $urandom_range(0, LOAD_WORDS - int'(c.sample_count)));
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    c.play_rate = 0;
                else if (pick < 65)
                    c.play_rate = 16'($urandom_range(8000, 65535));
            end
            else if (pick < 96)
                c = random_item(OP_WRITE);
            else
                c = random_item(OP_STOP);
            send_item(c);
            pace();
        end
    endtask

    // stimulus and final verdict
    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        error_count = 0;
        cycle_count = 0;
        gap_pct = 30;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        gap_pct = 0;
        load_sample_memory();
        gap_pct = 30;
        test_voice_lifecycle();
        test_voice_steal();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/mvsm_pkg.sv
rtl/core/mvsm_sample_ram.sv
rtl/core/mvsm_rate_div.sv
rtl/core/multi_voice_sample_mixer.sv
tb/sv/testbench.sv
